### design/npc_pkg.sv
// Package for the nearest palette color block: sizes, command codes and the
// command/status structs between controller and datapath. No dependencies.
package npc_pkg;

  localparam int PALETTE_DEPTH = 16;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int CH_W          = 8;
  localparam int ENTRY_W       = 3 * CH_W;
  localparam int SQ_W          = 2 * CH_W;
  localparam int DIST_W        = 18;
  localparam int SIZE_W        = 5;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic             load_pixel;
    logic             wr_entry;
    logic             rd_issue;
    logic [IDX_W-1:0] rd_addr;
    logic             load_out;
  } npc_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } npc_status_t;

endpackage

### design/npc_ctrl.sv
// Controller of the nearest palette color block: input handshake, scan
// sequencing and result hand-off. Depends on npc_pkg.
module npc_ctrl import npc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              command_i,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_data_i,
  input  npc_status_t       status_i,
  output logic              in_stall_o,
  output npc_cmd_t          cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  state_e            state_q;
  logic [SIZE_W-1:0] size_q;
  logic [IDX_W-1:0]  cnt_q;
  logic [IDX_W-1:0]  last_q;
  logic [IDX_W-1:0]  last_d;
  logic              accept;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  // Sizes of zero and above the depth are clamped into the valid range.
  always_comb begin
    if (size_q == '0) begin
      last_d = '0;
    end else if (size_q > SIZE_W'(PALETTE_DEPTH)) begin
      last_d = IDX_W'(PALETTE_DEPTH - 1);
    end else begin
      last_d = IDX_W'(size_q - SIZE_W'(1));
    end
  end

  always_comb begin
    cmd_o.load_pixel = accept && (command_i == CMD_QUERY);
    cmd_o.wr_entry   = accept && (command_i == CMD_WRITE);
    cmd_o.rd_issue   = (state_q == ST_SCAN);
    cmd_o.rd_addr    = cnt_q;
    cmd_o.load_out   = (state_q == ST_DRAIN) && !status_i.pipe_busy && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      size_q  <= SIZE_W'(1);
      cnt_q   <= '0;
      last_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_data_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && (command_i == CMD_QUERY)) begin
            cnt_q   <= '0;
            last_q  <= last_d;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt_q == last_q) begin
            state_q <= ST_DRAIN;
          end else begin
            cnt_q <= cnt_q + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          if (!status_i.pipe_busy && status_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### design/npc_datapath.sv
// Datapath of the nearest palette color block: palette memory, distance
// pipeline, best-entry tracking and the output register. Depends on npc_pkg.
module npc_datapath import npc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  npc_cmd_t          cmd_i,
  input  logic [IDX_W-1:0]  entry_index_i,
  input  logic [CH_W-1:0]   blue_i,
  input  logic [CH_W-1:0]   green_i,
  input  logic [CH_W-1:0]   red_i,
  input  logic              out_stall_i,
  output npc_status_t       status_o,
  output logic              out_valid_o,
  output logic [IDX_W-1:0]  nearest_index_o,
  output logic [CH_W-1:0]   out_blue_o,
  output logic [CH_W-1:0]   out_green_o,
  output logic [CH_W-1:0]   out_red_o,
  output logic [DIST_W-1:0] distance_squared_o
);

  logic [ENTRY_W-1:0] mem [PALETTE_DEPTH];

  logic [ENTRY_W-1:0] pix_q;
  logic               rd_vld_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic [ENTRY_W-1:0] rd_data_q;
  logic               sq_vld_q;
  logic [IDX_W-1:0]   sq_idx_q;
  logic [ENTRY_W-1:0] sq_entry_q;
  logic [SQ_W-1:0]    sq_b_q, sq_g_q, sq_r_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic [ENTRY_W-1:0] best_entry_q;
  logic [DIST_W-1:0]  best_dist_q;
  logic               out_valid_q, out_valid_d;
  logic [IDX_W-1:0]   out_idx_q;
  logic [ENTRY_W-1:0] out_entry_q;
  logic [DIST_W-1:0]  out_dist_q;

  logic [CH_W-1:0]    diff_b, diff_g, diff_r;
  logic [DIST_W-1:0]  sum_d;
  logic               take_best;

  function automatic logic [CH_W-1:0] abs_diff(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    diff_b = abs_diff(rd_data_q[CH_W-1:0], pix_q[CH_W-1:0]);
    diff_g = abs_diff(rd_data_q[2*CH_W-1:CH_W], pix_q[2*CH_W-1:CH_W]);
    diff_r = abs_diff(rd_data_q[3*CH_W-1:2*CH_W], pix_q[3*CH_W-1:2*CH_W]);
    sum_d  = DIST_W'(sq_b_q) + DIST_W'(sq_g_q) + DIST_W'(sq_r_q);
    // Entry zero always seeds the search; later entries win only when strictly closer.
    take_best = sq_vld_q && ((sq_idx_q == '0) || (sum_d < best_dist_q));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_entry) begin
      mem[entry_index_i] <= {red_i, green_i, blue_i};
    end
    rd_data_q <= mem[cmd_i.rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pixel) begin
      pix_q <= {red_i, green_i, blue_i};
    end
    rd_idx_q   <= cmd_i.rd_addr;
    sq_idx_q   <= rd_idx_q;
    sq_entry_q <= rd_data_q;
    sq_b_q     <= SQ_W'(diff_b) * SQ_W'(diff_b);
    sq_g_q     <= SQ_W'(diff_g) * SQ_W'(diff_g);
    sq_r_q     <= SQ_W'(diff_r) * SQ_W'(diff_r);
    if (take_best) begin
      best_idx_q   <= sq_idx_q;
      best_entry_q <= sq_entry_q;
      best_dist_q  <= sum_d;
    end
    if (cmd_i.load_out) begin
      out_idx_q   <= best_idx_q;
      out_entry_q <= best_entry_q;
      out_dist_q  <= best_dist_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      sq_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q    <= cmd_i.rd_issue;
      sq_vld_q    <= rd_vld_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    status_o.pipe_busy = rd_vld_q || sq_vld_q;
    status_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o        = out_valid_q;
  assign nearest_index_o    = out_idx_q;
  assign out_blue_o         = out_entry_q[CH_W-1:0];
  assign out_green_o        = out_entry_q[2*CH_W-1:CH_W];
  assign out_red_o          = out_entry_q[3*CH_W-1:2*CH_W];
  assign distance_squared_o = out_dist_q;

endmodule

### design/nearest_palette_color.sv
// Top level of the nearest palette color block: ties the controller to the
// datapath. Depends on npc_pkg, npc_ctrl and npc_datapath.
//
//  Channel  Handshake               Payload
//  -------  ----------------------  ------------------------------------------------
//  in       in_valid_i / in_stall_o command_i, entry_index_i, blue_i, green_i, red_i
//  out      out_valid_o / out_stall_i nearest_index_o, out_blue_o, out_green_o,
//                                   out_red_o, distance_squared_o
//  cfg      cfg_we_i                cfg_data_i (palette_size)
//
// A write item does not stall the input side. A query reads one palette entry per
// cycle from the palette memory, so it holds the input side from its acceptance
// until the registered read and the two-stage distance pipeline have drained.
// The result waits in an output register, so the next item is taken while it
// is stalled; a second query only finishes once that register is free.
// Reset clears control state and sets palette_size to one; the palette itself
// holds nothing defined until written.
module nearest_palette_color import npc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              command_i,
  input  logic [IDX_W-1:0]  entry_index_i,
  input  logic [CH_W-1:0]   blue_i,
  input  logic [CH_W-1:0]   green_i,
  input  logic [CH_W-1:0]   red_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IDX_W-1:0]  nearest_index_o,
  output logic [CH_W-1:0]   out_blue_o,
  output logic [CH_W-1:0]   out_green_o,
  output logic [CH_W-1:0]   out_red_o,
  output logic [DIST_W-1:0] distance_squared_o,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_data_i
);

  npc_cmd_t    cmd;
  npc_status_t status;

  npc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  npc_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .entry_index_i      (entry_index_i),
    .blue_i             (blue_i),
    .green_i            (green_i),
    .red_i              (red_i),
    .out_stall_i        (out_stall_i),
    .status_o           (status),
    .out_valid_o        (out_valid_o),
    .nearest_index_o    (nearest_index_o),
    .out_blue_o         (out_blue_o),
    .out_green_o        (out_green_o),
    .out_red_o          (out_red_o),
    .distance_squared_o (distance_squared_o)
  );

endmodule
